// File: rtl/core/dlp_argument_deframer_assert.svh
// Assertion macros used by the deframer checker.
`ifndef DLP_ARGUMENT_DEFRAMER_ASSERT_SVH
`define DLP_ARGUMENT_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define DLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define DLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: rtl/core/dlp_pkg.sv
// Types and constants for the argument deframer.
package dlp_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_PARSE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 1'd1;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Result kinds
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_ARG  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NOT_RESP = 2'd1;
    localparam logic [1:0] ERR_ID       = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    typedef enum logic [3:0] {
        PH_ID        = 4'd0,
        PH_COUNT     = 4'd1,
        PH_STATUS    = 4'd2,
        PH_ARG_FIRST = 4'd3,
        PH_TINY_SIZE = 4'd4,
        PH_SMALL_PAD = 4'd5,
        PH_SMALL_SZ  = 4'd6,
        PH_LONG_LO   = 4'd7,
        PH_LONG_SZ   = 4'd8,
        PH_DATA      = 4'd9,
        PH_DONE      = 4'd10,
        PH_DISCARD   = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        CLS_TINY  = 2'd0,
        CLS_SMALL = 2'd1,
        CLS_LONG  = 2'd2
    } arg_class_t;

    typedef struct packed {
        logic [7:0] data_byte_in;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_id;
        logic [7:0]  arg_count;
        logic [15:0] status_word;
        logic [7:0]  arg_index;
        logic [13:0] arg_id;
        logic [31:0] arg_size;
        logic [7:0]  data_byte_out;
        logic [1:0]  error_code;
        logic        last_of_arg;
    } out_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eom;
        arg_class_t arg_class;
    } item_t;

    typedef struct packed {
        logic       parse_mode;
        logic [6:0] expected_id;
    } cfg_t;

endpackage

// File: rtl/core/dlp_front.sv
// Front end: accepts bytes, classifies them and queues them for the parser.
module dlp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dlp_pkg::in_t     s_data,
    output logic             head_valid,
    output dlp_pkg::item_t   head,
    input  logic             pop
);

    dlp_pkg::item_t                 q_mem [dlp_pkg::Q_DEPTH];
    logic [dlp_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dlp_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dlp_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    dlp_pkg::item_t                 cls_item;
    logic                           push;

    // Class from the top two bits; only meaningful on an argument's first byte
    always_comb begin
        cls_item.data_byte = s_data.data_byte_in;
        cls_item.eom       = s_data.end_of_message;
        unique case (s_data.data_byte_in[7:6])
            2'b11:   cls_item.arg_class = dlp_pkg::CLS_LONG;
            2'b10:   cls_item.arg_class = dlp_pkg::CLS_SMALL;
            default: cls_item.arg_class = dlp_pkg::CLS_TINY;
        endcase
    end

    assign s_ready    = (cnt_reg != dlp_pkg::Q_CNT_W'(dlp_pkg::Q_DEPTH));
    assign push       = s_valid && s_ready;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + dlp_pkg::Q_CNT_W'(push) - dlp_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/core/dlp_back.sv
// Back end: message parser state machine and result register.
module dlp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  dlp_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  dlp_pkg::item_t   head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output dlp_pkg::out_t    m_data
);

    dlp_pkg::phase_t phase_reg, phase_next, phase_mid;
    logic [2:0]  fbc_reg, fbc_next;
    logic [7:0]  saved_id_reg, saved_id_next;
    logic [7:0]  saved_count_reg, saved_count_next;
    logic [15:0] saved_status_reg, saved_status_next;
    logic [7:0]  cur_index_reg, cur_index_next;
    logic [13:0] cur_arg_id_reg, cur_arg_id_next;
    logic [31:0] bytes_rem_reg, bytes_rem_next;
    logic        m_valid_reg, m_valid_next;
    dlp_pkg::out_t m_data_reg, m_data_next;

    logic [7:0]  b;
    logic        eom;
    logic [2:0]  fbc_inc;
    logic [31:0] br_shift;
    logic [31:0] br_dec;
    logic        last_arg;
    logic [1:0]  hdr_err;
    dlp_pkg::phase_t arg_after;
    logic        trunc;

    logic        res_has;
    logic [1:0]  res_kind;
    logic [1:0]  res_err;
    logic [7:0]  res_index;
    logic [13:0] res_id;
    logic [31:0] res_size;
    logic [7:0]  res_data;
    logic        res_last;
    logic        finish;

    assign b        = head.data_byte;
    assign eom      = head.eom;
    assign fbc_inc  = fbc_reg + 3'd1;
    assign br_shift = {bytes_rem_reg[23:0], b};
    assign br_dec   = bytes_rem_reg - 32'd1;
    assign last_arg = ({1'b0, cur_index_reg} + 9'd1) >= {1'b0, saved_count_reg};
    assign arg_after = last_arg ? dlp_pkg::PH_DONE : dlp_pkg::PH_ARG_FIRST;
    assign pop      = head_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (!saved_id_reg[7]) begin
            hdr_err = dlp_pkg::ERR_NOT_RESP;
        end else if (saved_id_reg[6:0] != cfg.expected_id) begin
            hdr_err = dlp_pkg::ERR_ID;
        end else begin
            hdr_err = dlp_pkg::ERR_NONE;
        end
    end

    // Next state
    always_comb begin
        phase_mid = phase_reg;
        unique case (phase_reg)
            dlp_pkg::PH_ID: begin
                phase_mid = dlp_pkg::PH_COUNT;
            end
            dlp_pkg::PH_COUNT: begin
                if (cfg.parse_mode) begin
                    phase_mid = dlp_pkg::PH_STATUS;
                end else begin
                    phase_mid = (b != 8'd0) ? dlp_pkg::PH_ARG_FIRST : dlp_pkg::PH_DONE;
                end
            end
            dlp_pkg::PH_STATUS: begin
                if (fbc_inc >= 3'd2) begin
                    if (hdr_err != dlp_pkg::ERR_NONE) begin
                        phase_mid = dlp_pkg::PH_DISCARD;
                    end else begin
                        phase_mid = (saved_count_reg != 8'd0) ? dlp_pkg::PH_ARG_FIRST
                                                              : dlp_pkg::PH_DONE;
                    end
                end
            end
            dlp_pkg::PH_ARG_FIRST: begin
                unique case (head.arg_class)
                    dlp_pkg::CLS_LONG:  phase_mid = dlp_pkg::PH_LONG_LO;
                    dlp_pkg::CLS_SMALL: phase_mid = dlp_pkg::PH_SMALL_PAD;
                    default:            phase_mid = dlp_pkg::PH_TINY_SIZE;
                endcase
            end
            dlp_pkg::PH_TINY_SIZE: begin
                phase_mid = (b == 8'd0) ? arg_after : dlp_pkg::PH_DATA;
            end
            dlp_pkg::PH_SMALL_PAD: begin
                phase_mid = dlp_pkg::PH_SMALL_SZ;
            end
            dlp_pkg::PH_SMALL_SZ: begin
                if (fbc_inc >= 3'd2) begin
                    phase_mid = (br_shift == 32'd0) ? arg_after : dlp_pkg::PH_DATA;
                end
            end
            dlp_pkg::PH_LONG_LO: begin
                phase_mid = dlp_pkg::PH_LONG_SZ;
            end
            dlp_pkg::PH_LONG_SZ: begin
                if (fbc_inc >= 3'd4) begin
                    phase_mid = (br_shift == 32'd0) ? arg_after : dlp_pkg::PH_DATA;
                end
            end
            dlp_pkg::PH_DATA: begin
                if (br_dec == 32'd0) begin
                    phase_mid = arg_after;
                end
            end
            default: begin
                phase_mid = phase_reg;
            end
        endcase
        trunc = eom && (phase_mid != dlp_pkg::PH_DONE) && (phase_mid != dlp_pkg::PH_DISCARD);
        phase_next = eom ? dlp_pkg::PH_ID : phase_mid;
    end

    // Datapath and result
    always_comb begin
        fbc_next          = fbc_reg;
        saved_id_next     = saved_id_reg;
        saved_count_next  = saved_count_reg;
        saved_status_next = saved_status_reg;
        cur_index_next    = cur_index_reg;
        cur_arg_id_next   = cur_arg_id_reg;
        bytes_rem_next    = bytes_rem_reg;
        res_has   = 1'b0;
        res_kind  = dlp_pkg::KIND_HDR;
        res_err   = dlp_pkg::ERR_NONE;
        res_index = '0;
        res_id    = '0;
        res_size  = '0;
        res_data  = '0;
        res_last  = 1'b0;
        finish    = 1'b0;

        unique case (phase_reg)
            dlp_pkg::PH_ID: begin
                saved_id_next     = b;
                saved_count_next  = '0;
                saved_status_next = '0;
                cur_index_next    = '0;
                cur_arg_id_next   = '0;
                bytes_rem_next    = '0;
                fbc_next          = '0;
            end
            dlp_pkg::PH_COUNT: begin
                saved_count_next = b;
                if (cfg.parse_mode) begin
                    fbc_next = '0;
                end else begin
                    res_has = 1'b1;
                end
            end
            dlp_pkg::PH_STATUS: begin
                saved_status_next = {saved_status_reg[7:0], b};
                fbc_next          = fbc_inc;
                if (fbc_inc >= 3'd2) begin
                    res_has = 1'b1;
                    if (hdr_err != dlp_pkg::ERR_NONE) begin
                        res_kind = dlp_pkg::KIND_ERR;
                        res_err  = hdr_err;
                    end
                end
            end
            dlp_pkg::PH_ARG_FIRST: begin
                bytes_rem_next = '0;
                fbc_next       = '0;
                if (head.arg_class == dlp_pkg::CLS_LONG) begin
                    cur_arg_id_next = {b[5:0], 8'd0};
                end else begin
                    cur_arg_id_next = {8'd0, b[5:0]};
                end
            end
            dlp_pkg::PH_TINY_SIZE: begin
                bytes_rem_next = {24'd0, b};
                finish         = 1'b1;
            end
            dlp_pkg::PH_SMALL_PAD: begin
                fbc_next = '0;
            end
            dlp_pkg::PH_SMALL_SZ: begin
                bytes_rem_next = br_shift;
                fbc_next       = fbc_inc;
                finish         = (fbc_inc >= 3'd2);
            end
            dlp_pkg::PH_LONG_LO: begin
                cur_arg_id_next = {cur_arg_id_reg[13:8], cur_arg_id_reg[7:0] | b};
                fbc_next        = '0;
            end
            dlp_pkg::PH_LONG_SZ: begin
                bytes_rem_next = br_shift;
                fbc_next       = fbc_inc;
                finish         = (fbc_inc >= 3'd4);
            end
            dlp_pkg::PH_DATA: begin
                res_has        = 1'b1;
                res_kind       = dlp_pkg::KIND_DATA;
                res_index      = cur_index_reg;
                res_id         = cur_arg_id_reg;
                res_size       = bytes_rem_reg;
                res_data       = b;
                res_last       = (bytes_rem_reg == 32'd1);
                bytes_rem_next = br_dec;
            end
            default: begin
                fbc_next = fbc_reg;
            end
        endcase

        if (finish) begin
            res_has   = 1'b1;
            res_kind  = dlp_pkg::KIND_ARG;
            res_index = cur_index_reg;
            res_id    = cur_arg_id_reg;
            res_size  = bytes_rem_next;
        end

        // Advance to the next argument header
        if (phase_mid == dlp_pkg::PH_ARG_FIRST && phase_reg != dlp_pkg::PH_COUNT &&
            phase_reg != dlp_pkg::PH_STATUS) begin
            cur_index_next = cur_index_reg + 8'd1;
        end

        if (eom) begin
            fbc_next = '0;
        end

        // Truncation replaces whatever this byte would have reported
        if (trunc) begin
            res_has   = 1'b1;
            res_kind  = dlp_pkg::KIND_ERR;
            res_err   = dlp_pkg::ERR_TRUNC;
            res_index = '0;
            res_id    = '0;
            res_size  = '0;
            res_data  = '0;
            res_last  = 1'b0;
        end

        m_data_next.kind          = res_kind;
        m_data_next.msg_id        = saved_id_next;
        m_data_next.arg_count     = saved_count_next;
        m_data_next.status_word   = saved_status_next;
        m_data_next.arg_index     = res_index;
        m_data_next.arg_id        = res_id;
        m_data_next.arg_size      = res_size;
        m_data_next.data_byte_out = res_data;
        m_data_next.error_code    = res_err;
        m_data_next.last_of_arg   = res_last;

        m_valid_next = pop ? res_has : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (pop && res_has) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= dlp_pkg::PH_ID;
            fbc_reg          <= '0;
            saved_id_reg     <= '0;
            saved_count_reg  <= '0;
            saved_status_reg <= '0;
            cur_index_reg    <= '0;
            cur_arg_id_reg   <= '0;
            bytes_rem_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg        <= phase_next;
                fbc_reg          <= fbc_next;
                saved_id_reg     <= saved_id_next;
                saved_count_reg  <= saved_count_next;
                saved_status_reg <= saved_status_next;
                cur_index_reg    <= cur_index_next;
                cur_arg_id_reg   <= cur_arg_id_next;
                bytes_rem_reg    <= bytes_rem_next;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/dlp_argument_deframer.sv
// Top level of the argument deframer: config registers, front queue and parser.
//
// Usage:
//   s_valid/s_ready/s_data carry one message byte per transfer, with
//   end_of_message set on the final byte. m_valid/m_ready/m_data carry at
//   most one result per byte: header done, argument header, data byte, or
//   error. Bytes that give no result (header fields, trailing bytes, bytes
//   after an error) are consumed silently.
//   cfg_we/cfg_addr/cfg_wdata write parse_mode (index 0) and expected_id
//   (index 1); write them only while no message byte is in flight.
// Timing:
//   One byte per cycle sustained while no result stalls on m_ready. A byte
//   transfers into the two-entry input queue, the parser takes it from
//   there, and the parser's output register holds the result on m_valid.
// Reset (aresetn low, synchronous): the queue empties, the parser returns
//   to the message id field, parse_mode resets to 1 and expected_id to 0.
// Stall: while m_ready is low a pending result holds, the parser stops,
//   and up to two more bytes gather in the queue before s_ready drops.
module dlp_argument_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dlp_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dlp_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [dlp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [dlp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    dlp_pkg::cfg_t  cfg_reg, cfg_next;
    logic           head_valid;
    dlp_pkg::item_t head;
    logic           pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                dlp_pkg::CFG_PARSE_MODE:  cfg_next.parse_mode  = cfg_wdata[0];
                dlp_pkg::CFG_EXPECTED_ID: cfg_next.expected_id = cfg_wdata[6:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.parse_mode  <= 1'b1;
            cfg_reg.expected_id <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dlp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    dlp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: rtl/core/dlp_checker.sv
// Port-level checks for the argument deframer, bound to the top level.
`include "dlp_argument_deframer_assert.svh"

module dlp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input dlp_pkg::out_t                  m_data
);

    // A stalled result holds
    `DLP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Error code appears with the error kind and only there
    `DLP_ASSERT_NOW(a_err_kind, m_valid, (m_data.kind == dlp_pkg::KIND_ERR) == (m_data.error_code != dlp_pkg::ERR_NONE))

    // Data fields stay clear outside data results
    `DLP_ASSERT_NOW(a_data_only, m_valid && m_data.kind != dlp_pkg::KIND_DATA, m_data.last_of_arg == 1'b0 && m_data.data_byte_out == 8'd0)

    // Last byte of an argument is the one with a single byte left
    `DLP_ASSERT_NOW(a_last_size, m_valid && m_data.kind == dlp_pkg::KIND_DATA, m_data.last_of_arg == (m_data.arg_size == 32'd1))

endmodule

bind dlp_argument_deframer dlp_checker u_chk (.*);
